@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bgi_pkg.sv @@
package bgi_pkg;

    localparam int MAX_Z_POINTS = 64;
    localparam int MAX_R_POINTS = 64;
    localparam int GRID_DEPTH   = MAX_Z_POINTS * MAX_R_POINTS;
    localparam int Z_AW         = $clog2(MAX_Z_POINTS);
    localparam int R_AW         = $clog2(MAX_R_POINTS);
    localparam int GRID_AW      = $clog2(GRID_DEPTH);
    localparam int Z_LW         = $clog2(MAX_Z_POINTS + 1);
    localparam int R_LW         = $clog2(MAX_R_POINTS + 1);

    localparam int CNT_W     = 7;
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int OUT_W     = 40;
    localparam int FRAC_W    = 24;
    localparam int DIV_STEPS = 24;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam logic [FRAC_W-1:0] FRAC_MAX     = 24'h7FFFFF;
    localparam logic [FRAC_W-1:0] FRAC_MIN_MAG = 24'h800000;

    typedef enum logic [1:0] {
        OP_LOAD_Z = 2'd0,
        OP_LOAD_R = 2'd1,
        OP_LOAD_D = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_Z_COUNT = 1'b0,
        CFG_R_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SAT        = 2'd1,
        ST_ZERO_WIDTH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        AS_SEARCH = 2'd0,
        AS_CLO    = 2'd1,
        AS_CHI    = 2'd2
    } t_addr_sel;

    typedef enum logic [1:0] {
        G_00 = 2'd0,
        G_01 = 2'd1,
        G_10 = 2'd2,
        G_11 = 2'd3
    } t_grid_sel;

    typedef enum logic [1:0] {
        MS_ROW0 = 2'd0,
        MS_ROW1 = 2'd1,
        MS_ZLO  = 2'd2,
        MS_ZHI  = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic      load;
        logic      query_start;
        logic      search_step;
        logic      slot_latch;
        t_addr_sel addr_sel;
        logic      cap_clo;
        logic      cap_chi;
        logic      div_start;
        t_grid_sel gsel;
        logic [3:0] cap_d;
        logic      frac_latch;
        t_mul_sel  mul_sel;
        logic      mul_en;
        logic      cap_row0;
        logic      cap_row1;
        logic      cap_plo;
        logic      cap_mz;
        logic      out_result;
        logic      out_zero;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic zero_width;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/bgi_ram.sv @@
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bgi_div.sv @@
module bgi_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bgi_pkg::VAL_W-1:0]  i_x,
    input  logic [bgi_pkg::VAL_W-1:0]  i_lo,
    input  logic [bgi_pkg::VAL_W-1:0]  i_hi,
    output logic                       o_done,
    output logic [bgi_pkg::FRAC_W-1:0] o_frac,
    output logic                       o_sat
);
    import bgi_pkg::*;

    logic [32:0]       w_num;
    logic [32:0]       w_den;
    logic [32:0]       w_mnum;
    logic [32:0]       w_mden;
    logic [33:0]       w_trial;
    logic              w_fit;
    logic [32:0]       r_rem;
    logic [32:0]       r_den;
    logic [23:0]       r_dsh;
    logic [FRAC_W-1:0] r_q;
    logic              r_big;
    logic              r_neg;
    logic [DIV_CW-1:0] r_cnt;

    assign w_num   = {1'b0, i_x} - {1'b0, i_lo};
    assign w_den   = {1'b0, i_hi} - {1'b0, i_lo};
    assign w_mnum  = w_num[32] ? (33'd0 - w_num) : w_num;
    assign w_mden  = w_den[32] ? (33'd0 - w_den) : w_den;
    assign w_trial = {r_rem, r_dsh[23]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CW'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_big <= ({8'd0, w_mnum} >= {w_mden, 8'd0});
            r_rem <= {8'd0, w_mnum[32:8]};
            r_dsh <= {w_mnum[7:0], 16'd0};
            r_den <= w_mden;
            r_neg <= w_num[32] ^ w_den[32];
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? 33'(w_trial - {1'b0, r_den}) : w_trial[32:0];
            r_dsh <= {r_dsh[22:0], 1'b0};
            r_q   <= {r_q[FRAC_W-2:0], w_fit};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_sat  = r_big || (r_q > FRAC_MAX);
            o_frac = o_sat ? FRAC_MAX : r_q;
        end else begin
            o_sat  = r_big || (r_q > FRAC_MIN_MAG);
            o_frac = o_sat ? FRAC_MIN_MAG : (FRAC_W'(0) - r_q);
        end
    end

    assign o_done = (r_cnt == '0);

endmodule

@@ hdl/bgi_datapath.sv @@
module bgi_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bgi_pkg::t_cmd             i_cmd,
    output bgi_pkg::t_stat            o_stat,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [bgi_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic [1:0]                i_op,
    input  logic [bgi_pkg::IDX_W-1:0] i_entry_index,
    input  logic [bgi_pkg::VAL_W-1:0] i_entry_value,
    input  logic [bgi_pkg::VAL_W-1:0] i_query_z,
    input  logic [bgi_pkg::VAL_W-1:0] i_query_r,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [bgi_pkg::OUT_W-1:0] o_interpolated_density,
    output logic [1:0]                o_status
);
    import bgi_pkg::*;

    logic [CNT_W-1:0]   r_zcount;
    logic [CNT_W-1:0]   r_rcount;
    logic [VAL_W-1:0]   r_qz;
    logic [VAL_W-1:0]   r_qr;
    logic [Z_LW-1:0]    w_nz;
    logic [R_LW-1:0]    w_nr;
    logic [Z_LW-1:0]    r_zlo;
    logic [Z_LW-1:0]    r_zlen;
    logic [R_LW-1:0]    r_rlo;
    logic [R_LW-1:0]    r_rlen;
    logic [Z_LW-1:0]    w_zhalf;
    logic [Z_LW-1:0]    w_zprobe;
    logic [R_LW-1:0]    w_rhalf;
    logic [R_LW-1:0]    w_rprobe;
    logic [Z_LW-1:0]    w_zs;
    logic [R_LW-1:0]    w_rs;
    logic [Z_AW-1:0]    r_iz;
    logic [R_AW-1:0]    r_ir;
    logic [Z_AW-1:0]    w_zaddr;
    logic [R_AW-1:0]    w_raddr;
    logic [GRID_AW-1:0] w_gaddr;
    logic [GRID_AW-1:0] w_grow0;
    logic [GRID_AW-1:0] w_grow1;
    logic               w_zwe;
    logic               w_rwe;
    logic               w_gwe;
    logic [VAL_W-1:0]   w_zrd;
    logic [VAL_W-1:0]   w_rrd;
    logic [VAL_W-1:0]   w_grd;
    logic [VAL_W-1:0]   r_zc_lo;
    logic [VAL_W-1:0]   r_zc_hi;
    logic [VAL_W-1:0]   r_rc_lo;
    logic [VAL_W-1:0]   r_rc_hi;
    logic [VAL_W-1:0]   r_d00;
    logic [VAL_W-1:0]   r_d01;
    logic [VAL_W-1:0]   r_d10;
    logic [VAL_W-1:0]   r_d11;
    logic               w_zdone;
    logic               w_rdone;
    logic [FRAC_W-1:0]  w_zfrac;
    logic [FRAC_W-1:0]  w_rfrac;
    logic               w_zsat;
    logic               w_rsat;
    logic signed [FRAC_W-1:0] r_fz;
    logic signed [FRAC_W-1:0] r_fr;
    logic               r_fsat;
    logic [FRAC_W-1:0]  w_fzmag;
    logic [FRAC_W-1:0]  w_frmag;
    logic [32:0]        w_diff0;
    logic [32:0]        w_diff1;
    logic signed [42:0] w_diffz;
    logic [41:0]        w_magz;
    logic [31:0]        w_ma;
    logic [FRAC_W-1:0]  w_mb;
    logic               w_mneg;
    logic [55:0]        r_prod;
    logic               r_mneg;
    logic [41:0]        w_rowm;
    logic signed [41:0] w_rowadd;
    logic signed [41:0] r_row0;
    logic signed [41:0] r_row1;
    logic [55:0]        r_plo;
    logic [65:0]        w_psum;
    logic [50:0]        r_mz;
    logic               r_mzneg;
    logic signed [51:0] w_v;
    logic               w_vhi;
    logic               w_vlo;
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;
    logic [1:0]         r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zcount <= CNT_W'(MAX_Z_POINTS);
            r_rcount <= CNT_W'(MAX_R_POINTS);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_Z_COUNT: r_zcount <= i_cfg_wdata;
                CFG_R_COUNT: r_rcount <= i_cfg_wdata;
                default: r_zcount <= r_zcount;
            endcase
        end
    end

    always_comb begin
        if (r_zcount < CNT_W'(2)) begin
            w_nz = Z_LW'(2);
        end else if (int'(r_zcount) > MAX_Z_POINTS) begin
            w_nz = Z_LW'(MAX_Z_POINTS);
        end else begin
            w_nz = Z_LW'(r_zcount);
        end
        if (r_rcount < CNT_W'(2)) begin
            w_nr = R_LW'(2);
        end else if (int'(r_rcount) > MAX_R_POINTS) begin
            w_nr = R_LW'(MAX_R_POINTS);
        end else begin
            w_nr = R_LW'(r_rcount);
        end
    end

    assign w_zhalf  = r_zlen >> 1;
    assign w_zprobe = r_zlo + w_zhalf;
    assign w_rhalf  = r_rlen >> 1;
    assign w_rprobe = r_rlo + w_rhalf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_qz   <= i_query_z;
            r_qr   <= i_query_r;
            r_zlo  <= '0;
            r_zlen <= w_nz;
            r_rlo  <= '0;
            r_rlen <= w_nr;
        end else if (i_cmd.search_step) begin
            if (r_zlen != '0) begin
                if (w_zrd < r_qz) begin
                    r_zlo  <= w_zprobe + 1'b1;
                    r_zlen <= r_zlen - w_zhalf - 1'b1;
                end else begin
                    r_zlen <= w_zhalf;
                end
            end
            if (r_rlen != '0) begin
                if (w_rrd < r_qr) begin
                    r_rlo  <= w_rprobe + 1'b1;
                    r_rlen <= r_rlen - w_rhalf - 1'b1;
                end else begin
                    r_rlen <= w_rhalf;
                end
            end
        end
    end

    always_comb begin
        w_zs = (r_zlo == '0) ? '0 : r_zlo - 1'b1;
        if (w_zs > w_nz - Z_LW'(2)) begin
            w_zs = w_nz - Z_LW'(2);
        end
        w_rs = (r_rlo == '0) ? '0 : r_rlo - 1'b1;
        if (w_rs > w_nr - R_LW'(2)) begin
            w_rs = w_nr - R_LW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_latch) begin
            r_iz <= Z_AW'(w_zs);
            r_ir <= R_AW'(w_rs);
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            AS_SEARCH: begin
                w_zaddr = Z_AW'(w_zprobe);
                w_raddr = R_AW'(w_rprobe);
            end
            AS_CLO: begin
                w_zaddr = r_iz;
                w_raddr = r_ir;
            end
            AS_CHI: begin
                w_zaddr = r_iz + 1'b1;
                w_raddr = r_ir + 1'b1;
            end
            default: begin
                w_zaddr = r_iz;
                w_raddr = r_ir;
            end
        endcase
        if (i_cmd.load) begin
            w_zaddr = Z_AW'(i_entry_index);
            w_raddr = R_AW'(i_entry_index);
        end
    end

    assign w_grow0 = GRID_AW'(r_iz) * GRID_AW'(MAX_R_POINTS);
    assign w_grow1 = GRID_AW'(r_iz + 1'b1) * GRID_AW'(MAX_R_POINTS);

    always_comb begin
        case (i_cmd.gsel)
            G_00:    w_gaddr = w_grow0 + GRID_AW'(r_ir);
            G_01:    w_gaddr = w_grow0 + GRID_AW'(r_ir + 1'b1);
            G_10:    w_gaddr = w_grow1 + GRID_AW'(r_ir);
            G_11:    w_gaddr = w_grow1 + GRID_AW'(r_ir + 1'b1);
            default: w_gaddr = w_grow0;
        endcase
        if (i_cmd.load) begin
            w_gaddr = GRID_AW'(i_entry_index);
        end
    end

    assign w_zwe = i_cmd.load && (i_op == OP_LOAD_Z) && (int'(i_entry_index) < MAX_Z_POINTS);
    assign w_rwe = i_cmd.load && (i_op == OP_LOAD_R) && (int'(i_entry_index) < MAX_R_POINTS);
    assign w_gwe = i_cmd.load && (i_op == OP_LOAD_D) && (int'(i_entry_index) < GRID_DEPTH);

    bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_Z_POINTS)) u_zram (
        .i_clk  (i_clk),
        .i_we   (w_zwe),
        .i_addr (w_zaddr),
        .i_wdata(i_entry_value),
        .o_rdata(w_zrd)
    );

    bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_R_POINTS)) u_rram (
        .i_clk  (i_clk),
        .i_we   (w_rwe),
        .i_addr (w_raddr),
        .i_wdata(i_entry_value),
        .o_rdata(w_rrd)
    );

    bgi_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_gram (
        .i_clk  (i_clk),
        .i_we   (w_gwe),
        .i_addr (w_gaddr),
        .i_wdata(i_entry_value),
        .o_rdata(w_grd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_clo) begin
            r_zc_lo <= w_zrd;
            r_rc_lo <= w_rrd;
        end
        if (i_cmd.cap_chi) begin
            r_zc_hi <= w_zrd;
            r_rc_hi <= w_rrd;
        end
        if (i_cmd.cap_d[0]) begin
            r_d00 <= w_grd;
        end
        if (i_cmd.cap_d[1]) begin
            r_d01 <= w_grd;
        end
        if (i_cmd.cap_d[2]) begin
            r_d10 <= w_grd;
        end
        if (i_cmd.cap_d[3]) begin
            r_d11 <= w_grd;
        end
    end

    bgi_div u_zdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_x    (r_qz),
        .i_lo   (r_zc_lo),
        .i_hi   (r_zc_hi),
        .o_done (w_zdone),
        .o_frac (w_zfrac),
        .o_sat  (w_zsat)
    );

    bgi_div u_rdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_x    (r_qr),
        .i_lo   (r_rc_lo),
        .i_hi   (r_rc_hi),
        .o_done (w_rdone),
        .o_frac (w_rfrac),
        .o_sat  (w_rsat)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.frac_latch) begin
            r_fz   <= $signed(w_zfrac);
            r_fr   <= $signed(w_rfrac);
            r_fsat <= w_zsat || w_rsat;
        end
    end

    assign w_fzmag = r_fz[FRAC_W-1] ? (FRAC_W'(0) - r_fz) : r_fz;
    assign w_frmag = r_fr[FRAC_W-1] ? (FRAC_W'(0) - r_fr) : r_fr;
    assign w_diff0 = {1'b0, r_d01} - {1'b0, r_d00};
    assign w_diff1 = {1'b0, r_d11} - {1'b0, r_d10};
    assign w_diffz = 43'(r_row1) - 43'(r_row0);
    assign w_magz  = w_diffz[42] ? 42'(-w_diffz) : 42'(w_diffz);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_ROW0: begin
                w_ma   = w_diff0[32] ? 32'(33'd0 - w_diff0) : w_diff0[31:0];
                w_mb   = w_frmag;
                w_mneg = w_diff0[32] ^ r_fr[FRAC_W-1];
            end
            MS_ROW1: begin
                w_ma   = w_diff1[32] ? 32'(33'd0 - w_diff1) : w_diff1[31:0];
                w_mb   = w_frmag;
                w_mneg = w_diff1[32] ^ r_fr[FRAC_W-1];
            end
            MS_ZLO: begin
                w_ma   = w_magz[31:0];
                w_mb   = w_fzmag;
                w_mneg = w_diffz[42] ^ r_fz[FRAC_W-1];
            end
            MS_ZHI: begin
                w_ma   = {22'd0, w_magz[41:32]};
                w_mb   = w_fzmag;
                w_mneg = w_diffz[42] ^ r_fz[FRAC_W-1];
            end
            default: begin
                w_ma   = '0;
                w_mb   = '0;
                w_mneg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= 56'(w_ma) * 56'(w_mb);
            r_mneg <= w_mneg;
        end
    end

    assign w_rowm   = 42'(r_prod[55:16]) + 42'(r_prod[15]);
    assign w_rowadd = r_mneg ? -$signed(w_rowm) : $signed(w_rowm);
    assign w_psum   = 66'(r_plo) + {r_prod[33:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_row0) begin
            r_row0 <= $signed({10'd0, r_d00}) + w_rowadd;
        end
        if (i_cmd.cap_row1) begin
            r_row1 <= $signed({10'd0, r_d10}) + w_rowadd;
        end
        if (i_cmd.cap_plo) begin
            r_plo <= r_prod;
        end
        if (i_cmd.cap_mz) begin
            r_mz    <= 51'(w_psum[65:16]) + 51'(w_psum[15]);
            r_mzneg <= r_mneg;
        end
    end

    assign w_v   = r_mzneg ? (52'(r_row0) - $signed({1'b0, r_mz}))
                           : (52'(r_row0) + $signed({1'b0, r_mz}));
    assign w_vhi = (w_v > 52'sh007FFFFFFFFF);
    assign w_vlo = (w_v < -52'sh008000000000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_result || i_cmd.out_zero) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            r_odata <= '0;
            r_ostat <= ST_ZERO_WIDTH;
        end else if (i_cmd.out_result) begin
            if (w_vhi) begin
                r_odata <= {1'b0, {(OUT_W-1){1'b1}}};
            end else if (w_vlo) begin
                r_odata <= {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                r_odata <= w_v[OUT_W-1:0];
            end
            r_ostat <= (r_fsat || w_vhi || w_vlo) ? ST_SAT : ST_OK;
        end
    end

    assign o_stat.search_done = (r_zlen == '0) && (r_rlen == '0);
    assign o_stat.zero_width  = (r_zc_lo == r_zc_hi) || (r_rc_lo == r_rc_hi);
    assign o_stat.div_done    = w_zdone && w_rdone;
    assign o_stat.out_free    = !r_ovalid || i_out_ready;

    assign o_out_valid            = r_ovalid;
    assign o_interpolated_density = r_odata;
    assign o_status               = r_ostat;

endmodule

@@ hdl/bgi_ctrl.sv @@
module bgi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_op,
    output logic           o_in_ready,
    input  bgi_pkg::t_stat i_stat,
    output bgi_pkg::t_cmd  o_cmd
);
    import bgi_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_SRD  = 24'h000002,
        S_SCMP = 24'h000004,
        S_SLOT = 24'h000008,
        S_CLO  = 24'h000010,
        S_CHI  = 24'h000020,
        S_CCAP = 24'h000040,
        S_CHK  = 24'h000080,
        S_D0   = 24'h000100,
        S_D1   = 24'h000200,
        S_D2   = 24'h000400,
        S_D3   = 24'h000800,
        S_D4   = 24'h001000,
        S_DIVW = 24'h002000,
        S_FRAC = 24'h004000,
        S_MR0  = 24'h008000,
        S_MR1  = 24'h010000,
        S_MR2  = 24'h020000,
        S_MZL  = 24'h040000,
        S_MZH  = 24'h080000,
        S_MZC  = 24'h100000,
        S_MFIN = 24'h200000,
        S_ZW   = 24'h400000,
        S_SPARE = 24'h800000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_QUERY) begin
                        o_cmd.query_start = 1'b1;
                        n_state = S_SRD;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SRD: begin
                o_cmd.addr_sel = AS_SEARCH;
                n_state = i_stat.search_done ? S_SLOT : S_SCMP;
            end
            S_SCMP: begin
                o_cmd.search_step = 1'b1;
                n_state = S_SRD;
            end
            S_SLOT: begin
                o_cmd.slot_latch = 1'b1;
                n_state = S_CLO;
            end
            S_CLO: begin
                o_cmd.addr_sel = AS_CLO;
                n_state = S_CHI;
            end
            S_CHI: begin
                o_cmd.addr_sel = AS_CHI;
                o_cmd.cap_clo  = 1'b1;
                n_state = S_CCAP;
            end
            S_CCAP: begin
                o_cmd.cap_chi = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.zero_width) begin
                    n_state = S_ZW;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_D0;
                end
            end
            S_D0: begin
                o_cmd.gsel = G_00;
                n_state = S_D1;
            end
            S_D1: begin
                o_cmd.gsel  = G_01;
                o_cmd.cap_d = 4'b0001;
                n_state = S_D2;
            end
            S_D2: begin
                o_cmd.gsel  = G_10;
                o_cmd.cap_d = 4'b0010;
                n_state = S_D3;
            end
            S_D3: begin
                o_cmd.gsel  = G_11;
                o_cmd.cap_d = 4'b0100;
                n_state = S_D4;
            end
            S_D4: begin
                o_cmd.cap_d = 4'b1000;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                o_cmd.frac_latch = 1'b1;
                n_state = S_MR0;
            end
            S_MR0: begin
                o_cmd.mul_sel = MS_ROW0;
                o_cmd.mul_en  = 1'b1;
                n_state = S_MR1;
            end
            S_MR1: begin
                o_cmd.cap_row0 = 1'b1;
                o_cmd.mul_sel  = MS_ROW1;
                o_cmd.mul_en   = 1'b1;
                n_state = S_MR2;
            end
            S_MR2: begin
                o_cmd.cap_row1 = 1'b1;
                n_state = S_MZL;
            end
            S_MZL: begin
                o_cmd.mul_sel = MS_ZLO;
                o_cmd.mul_en  = 1'b1;
                n_state = S_MZH;
            end
            S_MZH: begin
                o_cmd.cap_plo = 1'b1;
                o_cmd.mul_sel = MS_ZHI;
                o_cmd.mul_en  = 1'b1;
                n_state = S_MZC;
            end
            S_MZC: begin
                o_cmd.cap_mz = 1'b1;
                n_state = S_MFIN;
            end
            S_MFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ZW: begin
                if (i_stat.out_free) begin
                    o_cmd.out_zero = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bilinear_grid_interpolator.sv @@
// Bilinear interpolator over a non-uniform 2-D grid of Q16.16 densities.
// The input channel (valid/ready) carries op-tagged beats: loads of a Z
// center, an R center or a density entry, and queries. A load is written to
// its table when it is accepted and produces no output beat. A query
// produces one output beat holding the signed Q24.16 result and a status
// code. The input is ready again in the same cycle in which a query raises
// its output beat. Two lower-bound searches run side by side over the
// single-port axis tables, each probe a table read and then a compare
// (at most seven probes for 64 entries), followed by two center reads; then
// the 24-step restoring dividers run while the four grid reads proceed.
// Four multiplier passes follow, with the captures around them. A zero-width
// cell skips the arithmetic and answers with a zero result. One query is in
// work at a time. The output register holds a finished beat while the
// receiver stalls, and the next item is accepted meanwhile; a query then
// waits at its final step until the register frees. Reset clears the
// control state and sets both axis counts to 64. The tables are not cleared
// and must be loaded before they are queried. The user must write axis
// counts only while the block is idle; the block does not enforce it.
module bilinear_grid_interpolator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [bgi_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic [bgi_pkg::IDX_W-1:0] i_entry_index,
    input  logic [bgi_pkg::VAL_W-1:0] i_entry_value,
    input  logic [bgi_pkg::VAL_W-1:0] i_query_z,
    input  logic [bgi_pkg::VAL_W-1:0] i_query_r,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [bgi_pkg::OUT_W-1:0] o_interpolated_density,
    output logic [1:0]                o_status
);
    import bgi_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bgi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_op      (i_op),
        .o_in_ready(o_in_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    bgi_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_op                  (i_op),
        .i_entry_index         (i_entry_index),
        .i_entry_value         (i_entry_value),
        .i_query_z             (i_query_z),
        .i_query_r             (i_query_r),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_interpolated_density(o_interpolated_density),
        .o_status              (o_status)
    );

endmodule

@@ hdl/bgi_checker.sv @@
`include "assert_macros.svh"

module bgi_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [1:0]                i_op,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [bgi_pkg::OUT_W-1:0] o_interpolated_density,
    input logic [1:0]                o_status
);
    import bgi_pkg::*;

    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_interpolated_density) && $stable(o_status), "stalled output beat changed")
    `ASSERT_SAME(a_status_code, o_out_valid, o_status == ST_OK || o_status == ST_SAT || o_status == ST_ZERO_WIDTH, "undefined status code")
    `ASSERT_SAME(a_zero_width, o_out_valid && o_status == ST_ZERO_WIDTH, o_interpolated_density == '0, "zero-width result not zero")
    `ASSERT_NEXT(a_query_busy, i_in_valid && o_in_ready && i_op == OP_QUERY, !o_in_ready, "input ready right after a query")
    `ASSERT_SAME(a_no_fast_result, $rose(o_out_valid), !$past(i_in_valid && o_in_ready), "result one cycle after acceptance")

endmodule

bind bilinear_grid_interpolator bgi_checker u_bgi_checker (.*);
